/* sv/vc1_idu_pkg.sv */
// vc1_idu_pkg: shared constants and types for the vc-1 idu header parser
// unit type codes, sequence flag positions, frame kinds, result and window types
// no dependencies
`default_nettype none

package vc1_idu_pkg;

    localparam int HEADER_BYTES_DEF = 8;
    localparam int WIN_BITS         = 64;

    // idu type codes
    localparam logic [7:0] T_SEQ      = 8'h0F;
    localparam logic [7:0] T_ENTRY    = 8'h0E;
    localparam logic [7:0] T_FRAME    = 8'h0D;
    localparam logic [7:0] T_FIELD    = 8'h0C;
    localparam logic [7:0] T_SLICE    = 8'h0B;
    localparam logic [7:0] T_EOS      = 8'h0A;
    localparam logic [7:0] T_FRAME_UD = 8'h1D;
    localparam logic [7:0] T_FIELD_UD = 8'h1C;
    localparam logic [7:0] T_SLICE_UD = 8'h1B;

    // start code and emulation prevention bytes
    localparam logic [7:0] B_ZERO = 8'h00;
    localparam logic [7:0] B_ONE  = 8'h01;
    localparam logic [7:0] B_EPB  = 8'h03;

    // sequence flag bit positions
    localparam int F_ADV    = 0;
    localparam int F_ILACE  = 1;
    localparam int F_INTERP = 2;
    localparam int F_RANGE  = 3;
    localparam int F_HASB   = 4;

    typedef logic [WIN_BITS-1:0] t_window;

    typedef enum logic [1:0] {
        KIND_I = 2'd0,
        KIND_P = 2'd1,
        KIND_B = 2'd2
    } t_kind;

    typedef struct packed {
        logic        expect_type;
        t_window     window;
    } t_scan;

    typedef struct packed {
        logic [7:0]  unit_type;
        logic        unit_accepted;
        logic        frame_done;
        logic [1:0]  done_frame_kind;
        logic [13:0] coded_width;
        logic [13:0] coded_height;
        logic        is_advanced;
        logic        is_interlaced;
        logic        may_have_b;
        logic        frame_interp_flag;
        logic        range_reduce_flag;
    } t_result;

    function automatic logic continues_frame(input logic [7:0] t);
        continues_frame = (t == T_FRAME_UD) || (t == T_FIELD) || (t == T_FIELD_UD) ||
                          (t == T_SLICE) || (t == T_SLICE_UD) || (t == T_EOS);
    endfunction

endpackage

`default_nettype wire

/* sv/vc1_idu_scan.sv */
// vc1_idu_scan: byte level scanner, start code and emulation prevention detection
// and capture of the first payload bytes of each unit
// depends on vc1_idu_pkg
`default_nettype none

module vc1_idu_scan #(
    parameter int HEADER_BYTES = vc1_idu_pkg::HEADER_BYTES_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_advance,
    input  wire  [7:0]           i_byte,
    output vc1_idu_pkg::t_scan   o_scan
);

    localparam int CW  = $clog2(HEADER_BYTES + 1);
    localparam int WB  = HEADER_BYTES * 8;
    localparam int PAD = vc1_idu_pkg::WIN_BITS - WB;

    logic [1:0]    r_zero_run, n_zero_run;
    logic          r_expect, n_expect;
    logic          r_in_unit, n_in_unit;
    logic [WB-1:0] r_window, n_window;
    logic [CW-1:0] r_count, n_count;

    always_comb begin
        n_zero_run = r_zero_run;
        n_expect   = r_expect;
        n_in_unit  = r_in_unit;
        n_window   = r_window;
        n_count    = r_count;
        if (i_advance) begin
            if (r_expect) begin
                n_expect   = 1'b0;
                n_zero_run = 2'd0;
                n_in_unit  = 1'b1;
                n_window   = '0;
                n_count    = '0;
            end else if (r_zero_run == 2'd2 && i_byte == vc1_idu_pkg::B_ONE) begin
                n_expect   = 1'b1;
                n_zero_run = 2'd0;
            end else if (r_zero_run == 2'd2 && i_byte == vc1_idu_pkg::B_EPB) begin
                n_zero_run = 2'd0;
            end else begin
                if (r_in_unit && r_count < CW'(HEADER_BYTES)) begin
                    for (int k = 0; k < HEADER_BYTES; k++) begin
                        if (r_count == CW'(k)) begin
                            n_window[(HEADER_BYTES-1-k)*8 +: 8] = i_byte;
                        end
                    end
                    n_count = r_count + CW'(1);
                end
                // zero run saturates at two
                if (i_byte == vc1_idu_pkg::B_ZERO) begin
                    n_zero_run = (r_zero_run == 2'd2) ? 2'd2 : r_zero_run + 2'd1;
                end else begin
                    n_zero_run = 2'd0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_run <= 2'd0;
            r_expect   <= 1'b0;
            r_in_unit  <= 1'b0;
            r_window   <= '0;
            r_count    <= '0;
        end else begin
            r_zero_run <= n_zero_run;
            r_expect   <= n_expect;
            r_in_unit  <= n_in_unit;
            r_window   <= n_window;
            r_count    <= n_count;
        end
    end

    // first captured byte sits in the top bits, later bytes follow it, the low bits are zero padding
    assign o_scan.expect_type = r_expect;
    assign o_scan.window      = vc1_idu_pkg::t_window'(r_window) << PAD;

endmodule

`default_nettype wire

/* sv/vc1_idu_ctl.sv */
// vc1_idu_ctl: unit level control, finishes the previous unit, gates the new one
// and builds the result for each type byte
// depends on vc1_idu_pkg
`default_nettype none

module vc1_idu_ctl (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_take,
    input  wire  [7:0]            i_byte,
    input  vc1_idu_pkg::t_window  i_window,
    output vc1_idu_pkg::t_result  o_result
);

    logic [7:0]         r_cur_type;
    logic               r_cur_kept;
    logic               r_seq_seen, n_seq_seen;
    logic               r_entry_seen, n_entry_seen;
    logic               r_frame_open, n_frame_open;
    vc1_idu_pkg::t_kind r_open_kind, n_open_kind;
    logic [4:0]         r_flags, n_flags;
    logic [13:0]        r_width, n_width;
    logic [13:0]        r_height, n_height;

    logic               keep;
    logic               done;
    logic               fin_seq, fin_entry, fin_frame;
    logic [4:0]         seq_flags;
    vc1_idu_pkg::t_kind kind_cls;
    logic [3:0]         ubits;
    logic [4:0]         sbits;
    logic [1:0]         soff;

    // sequence header fields
    always_comb begin
        seq_flags = '0;
        if (i_window[63:62] == 2'b11) begin
            seq_flags[vc1_idu_pkg::F_ADV]    = 1'b1;
            seq_flags[vc1_idu_pkg::F_HASB]   = 1'b1;
            seq_flags[vc1_idu_pkg::F_ILACE]  = i_window[22];
            seq_flags[vc1_idu_pkg::F_INTERP] = i_window[20];
        end else begin
            seq_flags[vc1_idu_pkg::F_RANGE]  = i_window[39];
            seq_flags[vc1_idu_pkg::F_HASB]   = (i_window[38:36] != 3'd0);
            seq_flags[vc1_idu_pkg::F_INTERP] = i_window[33];
        end
    end

    // frame type from the picture header, using the flags in force
    always_comb begin
        kind_cls = vc1_idu_pkg::KIND_P;
        ubits    = i_window[63:60];
        sbits    = i_window[61:57];
        soff     = 2'd0;
        if (r_flags[vc1_idu_pkg::F_ADV]) begin
            if (r_flags[vc1_idu_pkg::F_ILACE] && i_window[63] && i_window[62]) begin
                // field interlaced picture
                if (i_window[61:59] <= 3'd2) begin
                    kind_cls = vc1_idu_pkg::KIND_I;
                end else if (i_window[61:59] == 3'd3) begin
                    kind_cls = vc1_idu_pkg::KIND_P;
                end else begin
                    kind_cls = vc1_idu_pkg::KIND_B;
                end
            end else begin
                if (r_flags[vc1_idu_pkg::F_ILACE] && i_window[63]) begin
                    ubits = i_window[61:58];
                end else if (r_flags[vc1_idu_pkg::F_ILACE]) begin
                    ubits = i_window[62:59];
                end
                if (!ubits[3]) begin
                    kind_cls = vc1_idu_pkg::KIND_P;
                end else if (!ubits[2]) begin
                    kind_cls = vc1_idu_pkg::KIND_B;
                end else if (!ubits[1]) begin
                    kind_cls = vc1_idu_pkg::KIND_I;
                end else if (!ubits[0]) begin
                    kind_cls = vc1_idu_pkg::KIND_B;
                end else begin
                    kind_cls = vc1_idu_pkg::KIND_P;
                end
            end
        end else begin
            soff = {1'b0, r_flags[vc1_idu_pkg::F_INTERP]} +
                   {1'b0, r_flags[vc1_idu_pkg::F_RANGE]};
            sbits = i_window[61:57] << soff;
            if (sbits[4]) begin
                kind_cls = vc1_idu_pkg::KIND_P;
            end else if (!r_flags[vc1_idu_pkg::F_HASB] || sbits[3]) begin
                kind_cls = vc1_idu_pkg::KIND_I;
            end else begin
                kind_cls = vc1_idu_pkg::KIND_B;
            end
        end
    end

    always_comb begin
        fin_seq   = r_cur_kept && (r_cur_type == vc1_idu_pkg::T_SEQ);
        fin_entry = r_cur_kept && (r_cur_type == vc1_idu_pkg::T_ENTRY);
        fin_frame = r_cur_kept && (r_cur_type == vc1_idu_pkg::T_FRAME);

        n_seq_seen   = r_seq_seen   | fin_seq;
        n_entry_seen = r_entry_seen | fin_entry;
        n_flags      = fin_seq ? seq_flags : r_flags;
        n_width      = r_width;
        n_height     = r_height;
        if (fin_seq && seq_flags[vc1_idu_pkg::F_ADV]) begin
            n_width  = {1'b0, i_window[47:36], 1'b0} + 14'd2;
            n_height = {1'b0, i_window[35:24], 1'b0} + 14'd2;
        end
        n_open_kind  = fin_frame ? kind_cls : r_open_kind;
        n_frame_open = r_frame_open | fin_frame;

        // wait for a sequence header, then for an entry point
        if (!n_seq_seen) begin
            keep = (i_byte == vc1_idu_pkg::T_SEQ);
        end else if (!n_entry_seen) begin
            keep = (i_byte == vc1_idu_pkg::T_ENTRY);
        end else begin
            keep = 1'b1;
        end
        done = keep && n_frame_open && !vc1_idu_pkg::continues_frame(i_byte);

        o_result.unit_type         = i_byte;
        o_result.unit_accepted     = keep;
        o_result.frame_done        = done;
        o_result.done_frame_kind   = done ? n_open_kind : vc1_idu_pkg::KIND_I;
        o_result.coded_width       = n_width;
        o_result.coded_height      = n_height;
        o_result.is_advanced       = n_flags[vc1_idu_pkg::F_ADV];
        o_result.is_interlaced     = n_flags[vc1_idu_pkg::F_ILACE];
        o_result.may_have_b        = n_flags[vc1_idu_pkg::F_HASB];
        o_result.frame_interp_flag = n_flags[vc1_idu_pkg::F_INTERP];
        o_result.range_reduce_flag = n_flags[vc1_idu_pkg::F_RANGE];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_type   <= 8'd0;
            r_cur_kept   <= 1'b0;
            r_seq_seen   <= 1'b0;
            r_entry_seen <= 1'b0;
            r_frame_open <= 1'b0;
            r_open_kind  <= vc1_idu_pkg::KIND_I;
            r_flags      <= 5'd0;
            r_width      <= 14'd0;
            r_height     <= 14'd0;
        end else if (i_take) begin
            r_cur_type   <= i_byte;
            r_cur_kept   <= keep;
            r_seq_seen   <= n_seq_seen;
            r_entry_seen <= n_entry_seen;
            r_frame_open <= n_frame_open & ~done;
            r_open_kind  <= n_open_kind;
            r_flags      <= n_flags;
            r_width      <= n_width;
            r_height     <= n_height;
        end
    end

endmodule

`default_nettype wire

/* sv/vc1_idu_header_parser.sv */
// result: a type byte passes the input register and then the result register; other bytes give none
// throughput: one byte per cycle; the input register holds only while a result waits
// and the output side stalls
// reset: synchronous, active low; clears the scanner, the header state and both valid flags
// vc1_idu_header_parser: top level, input register, scanner, unit control, result register
// depends on vc1_idu_pkg, vc1_idu_scan, vc1_idu_ctl
`default_nettype none

module vc1_idu_header_parser #(
    parameter int HEADER_BYTES = vc1_idu_pkg::HEADER_BYTES_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_stall,
    input  wire  [7:0]  i_stream_byte,
    output logic        o_valid,
    input  wire         i_stall,
    output logic [7:0]  o_unit_type,
    output logic        o_unit_accepted,
    output logic        o_frame_done,
    output logic [1:0]  o_done_frame_kind,
    output logic [13:0] o_coded_width,
    output logic [13:0] o_coded_height,
    output logic        o_is_advanced,
    output logic        o_is_interlaced,
    output logic        o_may_have_b,
    output logic        o_frame_interp_flag,
    output logic        o_range_reduce_flag
);

    logic                 r_in_valid;
    logic [7:0]           r_in_byte;
    logic                 r_out_valid;
    vc1_idu_pkg::t_result r_out;
    vc1_idu_pkg::t_result result;
    vc1_idu_pkg::t_scan   scan;
    logic                 advance;
    logic                 take;
    logic                 in_xfer;

    // a byte with no result always moves on, a type byte needs room in the result register
    assign advance = r_in_valid && (!scan.expect_type || !r_out_valid || !i_stall);
    assign take    = advance && scan.expect_type;
    assign o_stall = r_in_valid && !advance;
    assign in_xfer = i_valid && !o_stall;

    vc1_idu_scan #(
        .HEADER_BYTES (HEADER_BYTES)
    ) u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_byte    (r_in_byte),
        .o_scan    (scan)
    );

    vc1_idu_ctl u_ctl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (take),
        .i_byte   (r_in_byte),
        .i_window (scan.window),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_byte <= i_stream_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= result;
        end
    end

    assign o_valid             = r_out_valid;
    assign o_unit_type         = r_out.unit_type;
    assign o_unit_accepted     = r_out.unit_accepted;
    assign o_frame_done        = r_out.frame_done;
    assign o_done_frame_kind   = r_out.done_frame_kind;
    assign o_coded_width       = r_out.coded_width;
    assign o_coded_height      = r_out.coded_height;
    assign o_is_advanced       = r_out.is_advanced;
    assign o_is_interlaced     = r_out.is_interlaced;
    assign o_may_have_b        = r_out.may_have_b;
    assign o_frame_interp_flag = r_out.frame_interp_flag;
    assign o_range_reduce_flag = r_out.range_reduce_flag;

endmodule

`default_nettype wire

/* sv/vc1_idu_checker.sv */
// vc1_idu_checker: port level assertions for the vc-1 idu header parser, with its bind
// depends on vc1_idu_pkg and vc1_idu_header_parser
`default_nettype none

module vc1_idu_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        o_valid,
    input wire        i_stall,
    input wire        o_unit_accepted,
    input wire        o_frame_done,
    input wire [1:0]  o_done_frame_kind,
    input wire [13:0] o_coded_width,
    input wire [13:0] o_coded_height,
    input wire        o_is_advanced
);

    // reset leaves no result behind
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // a stalled result holds until it is taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_unit_accepted) &&
                                  $stable(o_frame_done) && $stable(o_done_frame_kind) &&
                                  $stable(o_coded_width) && $stable(o_coded_height)))
        else $error("stalled result changed");

    // only a kept unit can complete a frame
    a_done_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_frame_done) |-> o_unit_accepted)
        else $error("frame completed by a dropped unit");

    // kind is only reported with a completed frame, and is never the unused code
    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_frame_done || o_done_frame_kind == vc1_idu_pkg::KIND_I) &&
                     o_done_frame_kind != 2'd3))
        else $error("bad frame kind");

    // coded sizes are always even, and nonzero once an advanced header set them
    a_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (!o_coded_width[0] && !o_coded_height[0] &&
                     (!o_is_advanced || (o_coded_width != 14'd0 && o_coded_height != 14'd0))))
        else $error("bad coded size");

endmodule

bind vc1_idu_header_parser vc1_idu_checker u_vc1_idu_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_valid           (o_valid),
    .i_stall           (i_stall),
    .o_unit_accepted   (o_unit_accepted),
    .o_frame_done      (o_frame_done),
    .o_done_frame_kind (o_done_frame_kind),
    .o_coded_width     (o_coded_width),
    .o_coded_height    (o_coded_height),
    .o_is_advanced     (o_is_advanced)
);

`default_nettype wire
